FILE: src/pis_pkg.sv
// Shared types and constants for the PID step with integral separation.
// No dependencies; imported by pis_state and pid_integral_separation.
package pis_pkg;

    // Field and state widths
    localparam int VAL_W    = 16;  // target and measured values
    localparam int THR_W    = 12;  // throttle command
    localparam int GAIN_W   = 16;  // Q8.8 unsigned gains
    localparam int LIMIT_W  = 15;  // separation limit
    localparam int CLAMP_W  = 16;  // integral clamp
    localparam int ERR_W    = 17;  // error target - measured
    localparam int DIFF_W   = 18;  // error difference
    localparam int SUM_W    = 18;  // accumulated error sum
    localparam int DRIVE_W  = 32;  // output drive value
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;

    // Minimum throttle for integration
    localparam logic [THR_W-1:0] THROTTLE_MIN = 12'd180;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_AW-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_AW-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_AW-1:0] REG_SEP_LIMIT = 3'd3;
    localparam logic [CFG_AW-1:0] REG_INT_CLAMP = 3'd4;

    // Configuration reset values
    localparam logic [LIMIT_W-1:0] SEP_LIMIT_RST = 15'd250;
    localparam logic [CLAMP_W-1:0] INT_CLAMP_RST = 16'd2000;

    typedef logic signed [ERR_W-1:0]  err_t;
    typedef logic signed [DIFF_W-1:0] diff_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // Controller state carried from one step to the next
    typedef struct packed {
        err_t prev_error;
        sum_t error_sum;
        logic integrate;
    } ctrl_state_t;

endpackage

FILE: src/pid_integral_separation.sv
// Top level of the positional PID step with integral separation.
// Depends on pis_pkg and pis_state.

// Three-stage pipeline: an input register, a product register (three
// parallel multipliers of the 16-bit gains by the 17-bit error and the 18-bit
// error sum and difference, fed by the controller state) and an output
// register holding the summed, Q8.8-shifted and saturated drive value.
// One transfer is accepted every cycle while the output is not stalled; an
// item passes through the input, product and output registers in turn
// before m_axis_tvalid rises. The controller state (previous error, error
// sum, separation flag) advances as each item leaves the input register,
// so steps are applied strictly in order. Each stage holds when the stage
// behind it is full and stalled. Configuration registers are written through
// cfg_we/cfg_addr/cfg_wdata and apply to every item not yet past the input register.
module pid_integral_separation
    import pis_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration write port
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // [15:0] target_value, [31:16] measured_value, [32] armed, [44:33] throttle, [47:45] zero
    input  logic [47:0]       s_axis_tdata,
    // output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // [31:0] drive_value
    output logic [31:0]       m_axis_tdata
);

    localparam int PP_W  = GAIN_W + ERR_W + 1;   // gain_p * err
    localparam int PI_W  = GAIN_W + SUM_W + 1;   // gain_i * sum
    localparam int PD_W  = GAIN_W + DIFF_W + 1;  // gain_d * diff
    localparam int ACC_W = PD_W + 2;
    localparam int SHR   = 8;                    // Q8.8 fraction bits

    // Configuration registers
    logic [GAIN_W-1:0]  gain_p_reg;
    logic [GAIN_W-1:0]  gain_i_reg;
    logic [GAIN_W-1:0]  gain_d_reg;
    logic [LIMIT_W-1:0] sep_limit_reg;
    logic [CLAMP_W-1:0] int_clamp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            sep_limit_reg <= SEP_LIMIT_RST;
            int_clamp_reg <= INT_CLAMP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_GAIN_P:    gain_p_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_I:    gain_i_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_GAIN_D:    gain_d_reg    <= cfg_wdata[GAIN_W-1:0];
                REG_SEP_LIMIT: sep_limit_reg <= cfg_wdata[LIMIT_W-1:0];
                REG_INT_CLAMP: int_clamp_reg <= cfg_wdata[CLAMP_W-1:0];
                default:       ;
            endcase
        end
    end

    // Pipeline handshake
    logic a_valid_reg, b_valid_reg, c_valid_reg;
    logic ready_a, ready_b, ready_c;
    logic load_a, load_b, load_c;

    assign ready_c = !c_valid_reg || m_axis_tready;
    assign ready_b = !b_valid_reg || ready_c;
    assign ready_a = !a_valid_reg || ready_b;
    assign load_a  = s_axis_tvalid && ready_a;
    assign load_b  = a_valid_reg && ready_b;
    assign load_c  = b_valid_reg && ready_c;

    assign s_axis_tready = ready_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready_a) a_valid_reg <= s_axis_tvalid;
            if (ready_b) b_valid_reg <= a_valid_reg;
            if (ready_c) c_valid_reg <= b_valid_reg;
        end
    end

    // Stage A: input register
    logic signed [VAL_W-1:0] a_target_reg;
    logic signed [VAL_W-1:0] a_measured_reg;
    logic                    a_armed_reg;
    logic [THR_W-1:0]        a_throttle_reg;

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            a_target_reg   <= s_axis_tdata[15:0];
            a_measured_reg <= s_axis_tdata[31:16];
            a_armed_reg    <= s_axis_tdata[32];
            a_throttle_reg <= s_axis_tdata[44:33];
        end
    end

    // Controller state
    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    err_t        err;
    diff_t       diff;
    sum_t        sum_used;

    assign err      = ERR_W'(a_target_reg) - ERR_W'(a_measured_reg);
    assign diff     = DIFF_W'(err) - DIFF_W'(state_reg.prev_error);
    assign sum_used = state_reg.integrate ? state_reg.error_sum : '0;

    pis_state u_state (
        .state_cur        (state_reg),
        .err              (err),
        .measured_value   (a_measured_reg),
        .armed            (a_armed_reg),
        .throttle         (a_throttle_reg),
        .separation_limit (sep_limit_reg),
        .integral_clamp   (int_clamp_reg),
        .state_next       (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (load_b)
            state_reg <= state_next;
    end

    // Stage B: products, using the state left by the previous step
    logic signed [PP_W-1:0] prod_p, b_prod_p_reg;
    logic signed [PI_W-1:0] prod_i, b_prod_i_reg;
    logic signed [PD_W-1:0] prod_d, b_prod_d_reg;

    assign prod_p = PP_W'($signed({1'b0, gain_p_reg})) * PP_W'(err);
    assign prod_i = PI_W'($signed({1'b0, gain_i_reg})) * PI_W'(sum_used);
    assign prod_d = PD_W'($signed({1'b0, gain_d_reg})) * PD_W'(diff);

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            b_prod_p_reg <= prod_p;
            b_prod_i_reg <= prod_i;
            b_prod_d_reg <= prod_d;
        end
    end

    // Stage C: sum, arithmetic shift (floor), saturate
    logic signed [ACC_W-1:0]     acc;
    logic signed [ACC_W-SHR-1:0] acc_shr;
    logic signed [DRIVE_W-1:0]   drive;
    logic [DRIVE_W-1:0]          c_drive_reg;

    assign acc     = ACC_W'(b_prod_p_reg) + ACC_W'(b_prod_i_reg) + ACC_W'(b_prod_d_reg);
    assign acc_shr = acc[ACC_W-1:SHR];
    // the shifted sum is narrower than the output, so saturation reduces to sign extension
    assign drive   = DRIVE_W'(acc_shr);

    always_ff @(posedge clk)
    begin
        if (load_c)
            c_drive_reg <= drive;
    end

    assign m_axis_tvalid = c_valid_reg;
    assign m_axis_tdata  = c_drive_reg;

endmodule

FILE: src/pis_state.sv
// Next-state logic of the controller: separation flag, clamped error sum, previous error.
// Depends on pis_pkg.
module pis_state
    import pis_pkg::*;
(
    input  ctrl_state_t               state_cur,
    input  err_t                      err,
    input  logic signed [VAL_W-1:0]   measured_value,
    input  logic                      armed,
    input  logic [THR_W-1:0]          throttle,
    input  logic [LIMIT_W-1:0]        separation_limit,
    input  logic [CLAMP_W-1:0]        integral_clamp,
    output ctrl_state_t               state_next
);

    logic signed [LIMIT_W+1:0] limit_pos;
    logic signed [LIMIT_W+1:0] limit_neg;
    logic signed [LIMIT_W+1:0] meas_ext;
    logic signed [CLAMP_W:0]   clamp_pos;
    logic signed [CLAMP_W:0]   clamp_neg;
    logic signed [SUM_W:0]     sum_raw;
    logic                      active;
    logic                      separated;

    always_comb
    begin
        limit_pos = $signed({2'b00, separation_limit});
        limit_neg = -limit_pos;
        meas_ext  = (LIMIT_W+2)'(measured_value);
        clamp_pos = $signed({1'b0, integral_clamp});
        clamp_neg = -clamp_pos;
        sum_raw   = (SUM_W+1)'(state_cur.error_sum) + (SUM_W+1)'(err);
        active    = armed && (throttle >= THROTTLE_MIN);
        separated = (meas_ext > limit_pos) || (meas_ext < limit_neg);

        state_next            = state_cur;
        state_next.prev_error = err;
        priority if (!active)
        begin
            state_next.error_sum = '0;
        end
        else if (separated)
        begin
            state_next.integrate = 1'b0;
        end
        else
        begin
            state_next.integrate = 1'b1;
            // clamp to the symmetric bound
            priority if (sum_raw > (SUM_W+1)'(clamp_pos))
                state_next.error_sum = SUM_W'(clamp_pos);
            else if (sum_raw < (SUM_W+1)'(clamp_neg))
                state_next.error_sum = SUM_W'(clamp_neg);
            else
                state_next.error_sum = SUM_W'(sum_raw);
        end
    end

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for pid_integral_separation: stream stimulus, a cycle-free
// step predictor, an in-order checker and random source/sink flow control.
// Depends on pis_pkg and the pid_integral_separation RTL only.
module testbench
    import pis_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT   = 400000;  // cycles before the run is declared hung
    localparam int SETTLE      = 8;       // pipeline depth plus margin
    localparam int PHASE_STEPS = 250;

    // One controller step as offered on the input stream
    typedef struct {
        logic signed [VAL_W-1:0] target;
        logic signed [VAL_W-1:0] measured;
        logic                    armed;
        logic [THR_W-1:0]        throttle;
    } step_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_AW-1:0] cfg_addr = '0;
    logic [CFG_DW-1:0] cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // [15:0] target_value, [31:16] measured_value, [32] armed, [44:33] throttle, [47:45] zero
    logic [47:0]       s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // [31:0] drive_value
    logic [31:0]       m_axis_tdata;

    // Shadow configuration
    logic [GAIN_W-1:0]  kp = '0;
    logic [GAIN_W-1:0]  ki = '0;
    logic [GAIN_W-1:0]  kd = '0;
    logic [LIMIT_W-1:0] sep_limit = SEP_LIMIT_RST;
    logic [CLAMP_W-1:0] sum_clamp = INT_CLAMP_RST;

    // Shadow controller state
    err_t last_error = '0;
    sum_t err_acc = '0;
    logic integ_on = 1'b0;

    logic [DRIVE_W-1:0] drive_expected[$];

    int error_count = 0;
    int steps_sent = 0;
    int results_checked = 0;
    int n_integrating = 0;
    int n_separated = 0;
    int n_idle_clear = 0;
    int n_settings = 0;
    int input_stalls = 0;
    int cycles = 0;
    int burst_left = 0;
    int hold_request = 0;

    pid_integral_separation uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // Cycle count, input stall count and hang guard
    always @(posedge clk)
    begin
        cycles++;
        if (s_axis_tvalid && !s_axis_tready)
            input_stalls++;
        if (cycles > RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     drive_expected.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (error_count < 30)
            $display("[%0t] %s: expected %0d, got %0d", $realtime, what,
                     $signed(want), $signed(got));
        error_count++;
    endtask

    function automatic step_t mk_step(input int target, input int measured, input bit armed,
                                      input int throttle);
        step_t st;
        st.target   = target[VAL_W-1:0];
        st.measured = measured[VAL_W-1:0];
        st.armed    = armed;
        st.throttle = throttle[THR_W-1:0];
        return st;
    endfunction

    // Expected drive for one step, then advance the shadow state
    function automatic void predict_drive(input step_t st);
        longint err, diff, acc, res;
        int     meas, lim, bound, s;
        err  = longint'(st.target) - longint'(st.measured);
        diff = err - longint'(last_error);
        acc  = longint'(kp) * err + longint'(kd) * diff;
        if (integ_on)
            acc += longint'(ki) * longint'(err_acc);
        res = acc >>> 8;
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        drive_expected.push_back(res[DRIVE_W-1:0]);

        if (st.armed && st.throttle >= THROTTLE_MIN)
        begin
            meas = st.measured;
            lim  = int'(sep_limit);
            if (meas > lim || meas < -lim)
            begin
                integ_on = 1'b0;
                n_separated++;
            end
            else
            begin
                bound = int'(sum_clamp);
                s = int'(err_acc) + int'(err);
                if (s > bound)
                    s = bound;
                if (s < -bound)
                    s = -bound;
                err_acc  = s[SUM_W-1:0];
                integ_on = 1'b1;
                n_integrating++;
            end
        end
        else
        begin
            err_acc = '0;
            n_idle_clear++;
        end
        last_error = err[ERR_W-1:0];
    endfunction

    // Offer one step in bursts with random gaps; returns once it is transferred
    task automatic send_step(input step_t st);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, st.throttle, st.armed, st.measured, st.target};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_drive(st);
        steps_sent++;
    endtask

    // Stop offering and wait until every result is out and the pipe is empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (drive_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_GAIN_P:    kp = val;
            REG_GAIN_I:    ki = val;
            REG_GAIN_D:    kd = val;
            REG_SEP_LIMIT: sep_limit = val[LIMIT_W-1:0];
            REG_INT_CLAMP: sum_clamp = val;
            default: ;
        endcase
    endtask

    task automatic configure(input int p, input int i, input int d, input int lim,
                             input int clamp);
        drain();
        write_reg(REG_GAIN_P, p[CFG_DW-1:0]);
        write_reg(REG_GAIN_I, i[CFG_DW-1:0]);
        write_reg(REG_GAIN_D, d[CFG_DW-1:0]);
        write_reg(REG_SEP_LIMIT, {1'b0, lim[LIMIT_W-1:0]});
        write_reg(REG_INT_CLAMP, clamp[CFG_DW-1:0]);
        n_settings++;
    endtask

    // Mostly integrating steps inside the window, some on its edge, some idle-throttle steps, some noise
    function automatic step_t random_step();
        step_t st;
        int    pick, lim, m, t;
        pick = $urandom_range(99);
        lim  = int'(sep_limit);
        st.target   = VAL_W'($urandom);
        st.measured = VAL_W'($urandom);
        st.armed    = 1'($urandom);
        st.throttle = THR_W'($urandom);
        if (pick < 75)
        begin
            if (pick < 65)
            begin
                st.armed    = 1'b1;
                st.throttle = ($urandom_range(7) == 0) ? THROTTLE_MIN
                                                       : THR_W'($urandom_range(180, 4095));
                if ($urandom_range(9) == 0)
                    m = ($urandom_range(1) ? lim : -lim) + int'($urandom_range(1));
                else
                    m = $urandom_range(2 * lim) - lim;
                st.measured = m[VAL_W-1:0];
            end
            else
            begin
                st.armed    = 1'($urandom_range(1));
                st.throttle = st.armed ? THR_W'($urandom_range(0, 179)) : THR_W'($urandom);
            end
            if ($urandom_range(1))
            begin
                t = int'(st.measured) + $urandom_range(600) - 300;
                st.target = t[VAL_W-1:0];
            end
        end
        return st;
    endfunction

    // Receiver: ready runs with changing stall density, plus requested long holds
    initial
    begin : result_sink
        int stall_pct, run_left, held;
        run_left = 0;
        stall_pct = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                held = hold_request;
                hold_request = 0;
                m_axis_tready <= 1'b0;
                repeat (held) @(posedge clk);
            end
            else
            begin
                if (run_left == 0)
                begin
                    case ($urandom_range(4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 20;
                        3:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    run_left = $urandom_range(16, 128);
                end
                run_left--;
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Compare each output transfer with the oldest expected drive
    always @(posedge clk)
    begin : result_check
        logic [DRIVE_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (drive_expected.size() == 0)
                report_mismatch("unexpected drive_value", '0, m_axis_tdata);
            else
            begin
                want = drive_expected.pop_front();
                if (m_axis_tdata !== want)
                    report_mismatch("drive_value", want, m_axis_tdata);
                results_checked++;
            end
        end
    end

    // Defaults after reset: zero gains, state still advances
    task automatic test_reset_defaults();
        send_step(mk_step(32767, -32768, 1'b1, 4095));
        send_step(mk_step(-32768, 32767, 1'b0, 0));
        send_step(mk_step(0, 0, 1'b1, 180));
    endtask

    // Extremes, throttle threshold, separation boundary, clamp limits
    task automatic test_directed();
        configure(65535, 65535, 65535, 250, 2000);
        send_step(mk_step(32767, -32768, 1'b1, 4095));   // far outside limit
        send_step(mk_step(-32768, 32767, 1'b1, 4095));   // largest error swing
        send_step(mk_step(100, 0, 1'b1, 180));           // threshold throttle
        send_step(mk_step(100, 250, 1'b1, 180));         // on the positive limit
        send_step(mk_step(100, -250, 1'b1, 180));        // on the negative limit
        send_step(mk_step(100, 251, 1'b1, 180));         // just past the limit
        send_step(mk_step(100, -251, 1'b1, 4095));
        send_step(mk_step(0, 0, 1'b1, 179));             // low throttle clears sum
        send_step(mk_step(0, 0, 1'b0, 4095));            // disarmed
        send_step(mk_step(32767, 0, 1'b1, 500));         // hits upper clamp
        send_step(mk_step(32767, 0, 1'b1, 500));
        send_step(mk_step(-32768, 0, 1'b1, 500));        // swings to lower clamp
        send_step(mk_step(-32768, 0, 1'b1, 500));

        // zero clamp pins the sum while integrating
        drain();
        write_reg(REG_INT_CLAMP, 16'd0);
        send_step(mk_step(5000, 0, 1'b1, 200));
        send_step(mk_step(-5000, 0, 1'b1, 200));

        // widest window and clamp
        configure(65535, 65535, 65535, 32767, 65535);
        send_step(mk_step(32767, -32767, 1'b1, 4095));
        send_step(mk_step(32767, -32767, 1'b1, 4095));
        send_step(mk_step(-32768, 32767, 1'b1, 4095));

        // zero window: only a zero measurement integrates
        drain();
        write_reg(REG_SEP_LIMIT, 16'd0);
        send_step(mk_step(40, 0, 1'b1, 300));
        send_step(mk_step(40, 1, 1'b1, 300));
        send_step(mk_step(40, -1, 1'b1, 300));
    endtask

    task automatic test_random_phase(input int p, input int i, input int d, input int lim,
                                     input int clamp);
        configure(p, i, d, lim, clamp);
        repeat (PHASE_STEPS) send_step(random_step());
    endtask

    // Long output hold while input keeps coming: pipeline must fill and back up
    task automatic test_backpressure();
        configure($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(1000), $urandom_range(5000));
        hold_request = 300;
        repeat (60) send_step(random_step());
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_directed();
        test_random_phase(256, 64, 128, 250, 2000);
        test_random_phase($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(32767), $urandom_range(65535));
        test_random_phase(65535, 65535, 65535, 32767, 65535);
        test_random_phase(0, 0, 0, 0, 0);
        test_random_phase($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(32767), $urandom_range(65535));
        test_random_phase($urandom_range(1024), $urandom_range(1024), $urandom_range(1024),
                          $urandom_range(2000), $urandom_range(4000));
        test_backpressure();
        drain();

        $display("Covered %0d steps over %0d gain settings: %0d integrating, %0d separated,",
                 steps_sent, n_settings, n_integrating, n_separated);
        $display("%0d idle clears; %0d results checked, input backed up %0d cycles, %0d errors",
                 n_idle_clear, results_checked, input_stalls, error_count);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
